/* rtl/tbrl_pkg.sv */
`default_nettype none

package tbrl_pkg;

	// Field and register widths
	localparam int RATE_W  = 24;
	localparam int BURST_W = 16;
	localparam int WAIT_W  = 32;
	localparam int TIME_W  = 64;
	localparam int COST_W  = 20;
	localparam int UCOST_W = 26;   // cost in 1/60000 token units
	localparam int LEVEL_W = 57;   // signed bucket level
	localparam int CAP_W   = 34;   // capacity, never negative
	localparam int ACC_W   = 58;   // saturating refill product
	localparam int DVD_W   = 58;   // wait dividend and quotient
	localparam int IDX_W   = 3;

	// Sequencer step counts
	localparam int MUL_STEPS = RATE_W;      // one multiplier bit a cycle
	localparam int DIV_STEPS = DVD_W / 2;   // two quotient bits a cycle
	localparam int STEP_W    = 5;

	// Unit conversions
	localparam logic [15:0] UNITS_PER_TOKEN = 16'd60000;
	localparam logic [9:0]  CAP_PER_RPM     = 10'd1000;
	localparam logic [5:0]  UNITS_PER_MILLI = 6'd60;

	// Refill product saturates here, above any possible room in the bucket
	localparam logic [ACC_W-1:0] ACC_SAT = {1'b1, {(ACC_W-1){1'b0}}};

	// Register indexes
	localparam logic [IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [IDX_W-1:0] CFG_RATE   = 3'd1;
	localparam logic [IDX_W-1:0] CFG_BURST  = 3'd2;
	localparam logic [IDX_W-1:0] CFG_WAIT   = 3'd3;

	// Request functions
	localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
	localparam logic [1:0] FUNC_REFUND  = 2'd1;
	localparam logic [1:0] FUNC_PEEK    = 2'd2;

	// Controller to datapath commands, at most one per cycle
	typedef struct packed {
		logic load;
		logic seed;
		logic mul_load;
		logic mul_step;
		logic refill_apply;
		logic refund;
		logic acq_eval;
		logic div_step;
		logic judge;
		logic publish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] func;
		logic       acq_active;
		logic       refund_active;
		logic       rate_nz;
		logic       seeded;
		logic       time_ahead;
		logic       covers;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

/* rtl/token_bucket_rate_limiter.sv */
// Channel | Handshake             | Payload
// cfg     | cfg_valid / cfg_ready | cfg_index[2:0], cfg_data[31:0]
// in      | in_valid / in_ready   | func[1:0], now_ms[63:0], cost_milli[19:0]
// out     | out_valid / out_ready | allowed, retry_after_ms[31:0], token_level[56:0]
//
// One request at a time. Refund, free or passthrough requests go from the decide step
// straight to the result; a peek that refills runs the shift-add refill multiply and the
// clamp; an acquire the bucket covers adds the cost check; a reserved or rejected acquire
// also runs the radix-4 wait divider and the judge step. The multiply is skipped when the
// clock has not moved on. A finished result sits in the output register, so the next
// request is taken while it waits; only a second result waiting stalls the sequencer.
// Reset empties the bucket; the first request after reset or after any register write
// fills it to capacity. cfg_ready is always high.
`default_nettype none

module token_bucket_rate_limiter (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tbrl_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [31:0]                         cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          func,
	input  wire logic [tbrl_pkg::TIME_W-1:0]         now_ms,
	input  wire logic [tbrl_pkg::COST_W-1:0]         cost_milli,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     allowed,
	output logic [tbrl_pkg::WAIT_W-1:0]              retry_after_ms,
	output logic signed [tbrl_pkg::LEVEL_W-1:0]      token_level
);

	tbrl_pkg::cmd_t cmd;
	tbrl_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	tbrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tbrl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_func        (func),
		.in_now         (now_ms),
		.in_cost        (cost_milli),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.allowed        (allowed),
		.retry_after_ms (retry_after_ms),
		.token_level    (token_level)
	);

	// A taken request closes the input until its result is published
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken while one is in flight");

	// Results only appear from a publish command
	a_rose_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.publish))
		else $error("result valid without publish");

	// Rejected requests never carry a wait
	a_reject_nodelay: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !allowed) |-> (retry_after_ms == '0))
		else $error("rejected request with non-zero delay");

	// The sequencer issues one datapath command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping datapath commands");

endmodule

`default_nettype wire

/* rtl/tbrl_dp.sv */
`default_nettype none

module tbrl_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	input  wire logic [tbrl_pkg::IDX_W-1:0]           cfg_index,
	input  wire logic [31:0]                          cfg_data,
	input  wire logic [1:0]                           in_func,
	input  wire logic [tbrl_pkg::TIME_W-1:0]          in_now,
	input  wire logic [tbrl_pkg::COST_W-1:0]          in_cost,
	input  wire logic                                 out_ready,
	input  wire tbrl_pkg::cmd_t                       cmd,
	output tbrl_pkg::sts_t                            sts,
	output logic                                      out_valid,
	output logic                                      allowed,
	output logic [tbrl_pkg::WAIT_W-1:0]               retry_after_ms,
	output logic signed [tbrl_pkg::LEVEL_W-1:0]       token_level
);

	// Configuration
	logic                             en_q;
	logic [tbrl_pkg::RATE_W-1:0]      rate_q;
	logic [tbrl_pkg::BURST_W-1:0]     burst_q;
	logic [tbrl_pkg::WAIT_W-1:0]      wait_q;

	// Bucket state
	logic                               primed_q;
	logic                               seeded_q;
	logic signed [tbrl_pkg::LEVEL_W-1:0] level_q;
	logic [tbrl_pkg::TIME_W-1:0]        last_q;

	// Current request
	logic [1:0]                       func_q;
	logic [tbrl_pkg::TIME_W-1:0]      now_q;
	logic [tbrl_pkg::COST_W-1:0]      cost_q;
	logic                             allow_w_q;
	logic [tbrl_pkg::WAIT_W-1:0]      delay_w_q;

	// Shift-add multiplier and restoring divider
	logic [tbrl_pkg::LEVEL_W-1:0]     mcand_q;
	logic [tbrl_pkg::RATE_W-1:0]      mplier_q;
	logic [tbrl_pkg::ACC_W-1:0]       acc_q;
	logic [tbrl_pkg::DVD_W-1:0]       dvd_q;
	logic [tbrl_pkg::RATE_W-1:0]      rem_q;

	// Result register
	logic                             out_valid_q;
	logic                             allowed_q;
	logic [tbrl_pkg::WAIT_W-1:0]      delay_q;
	logic signed [tbrl_pkg::LEVEL_W-1:0] token_q;

	logic                             cfg_hit;
	logic [31:0]                      burst_units;
	logic [tbrl_pkg::CAP_W-1:0]       rate_units;
	logic [tbrl_pkg::CAP_W-1:0]       cap;
	logic [tbrl_pkg::UCOST_W-1:0]     cost_units;
	logic [tbrl_pkg::TIME_W-1:0]      delta;
	logic [tbrl_pkg::ACC_W-1:0]       add_op;
	logic signed [59:0]               clamp_sum;
	logic signed [59:0]               cap_ext;
	logic [tbrl_pkg::LEVEL_W-1:0]     clamp_lvl;
	logic signed [57:0]               lvl_ext;
	logic signed [57:0]               cost_ext;
	logic [tbrl_pkg::DVD_W-1:0]       deficit;
	logic [tbrl_pkg::DVD_W-1:0]       dividend;
	logic [tbrl_pkg::LEVEL_W-1:0]     lvl_less;
	logic [58:0]                      mul_sum;
	logic [tbrl_pkg::ACC_W-1:0]       acc_nxt;
	logic [25:0]                      d1;
	logic [25:0]                      d2;
	logic                             ge1;
	logic                             ge2;
	logic [tbrl_pkg::RATE_W-1:0]      r1;
	logic [tbrl_pkg::RATE_W-1:0]      r2;
	logic                             rate_nz;
	logic                             active;

	// Register decode; writes beyond the list are dropped
	always_comb begin
		case (cfg_index)
			tbrl_pkg::CFG_ENABLE,
			tbrl_pkg::CFG_RATE,
			tbrl_pkg::CFG_BURST,
			tbrl_pkg::CFG_WAIT: cfg_hit = 1'b1;
			default:            cfg_hit = 1'b0;
		endcase
	end

	// Capacity: zero with no rate, else burst tokens, else one second of rate with a floor of one token
	assign burst_units = 32'(burst_q) * 32'(tbrl_pkg::UNITS_PER_TOKEN);
	assign rate_units  = tbrl_pkg::CAP_W'(rate_q) * tbrl_pkg::CAP_W'(tbrl_pkg::CAP_PER_RPM);
	always_comb begin
		if (rate_q == '0) begin
			cap = '0;
		end else if (burst_q != '0) begin
			cap = {2'b0, burst_units};
		end else if (rate_units < tbrl_pkg::CAP_W'(tbrl_pkg::UNITS_PER_TOKEN)) begin
			cap = tbrl_pkg::CAP_W'(tbrl_pkg::UNITS_PER_TOKEN);
		end else begin
			cap = rate_units;
		end
	end

	assign cost_units = tbrl_pkg::UCOST_W'(cost_q) *
	                    tbrl_pkg::UCOST_W'(tbrl_pkg::UNITS_PER_MILLI);
	assign delta      = now_q - last_q;
	assign rate_nz    = (rate_q != '0);
	assign active     = en_q && rate_nz && (cost_q != '0);

	// Shared clamp adder: refill product or refunded cost, capped at capacity
	assign add_op    = cmd.refund ? {32'b0, cost_units} : acc_q;
	assign clamp_sum = $signed({{3{level_q[56]}}, level_q}) + $signed({2'b0, add_op});
	assign cap_ext   = $signed({26'b0, cap});
	assign clamp_lvl = (clamp_sum >= cap_ext) ? {23'b0, cap} : clamp_sum[56:0];

	// Acquire compare and deficit
	assign lvl_ext  = {level_q[56], level_q};
	assign cost_ext = $signed({32'b0, cost_units});
	assign deficit  = cost_ext - lvl_ext;
	assign dividend = deficit + {34'b0, rate_q} - 58'd1;
	assign lvl_less = level_q - $signed({31'b0, cost_units});

	// Multiplier step, MSB of the rate first, sticky saturation
	assign mul_sum = {acc_q, 1'b0} + (mplier_q[23] ? {2'b0, mcand_q} : 59'b0);
	assign acc_nxt = (|mul_sum[58:57]) ? tbrl_pkg::ACC_SAT : mul_sum[57:0];

	// Divider step, two restoring iterations
	assign d1  = {1'b0, rem_q, dvd_q[57]} - {2'b0, rate_q};
	assign ge1 = !d1[25];
	assign r1  = ge1 ? d1[23:0] : {rem_q[22:0], dvd_q[57]};
	assign d2  = {1'b0, r1, dvd_q[56]} - {2'b0, rate_q};
	assign ge2 = !d2[25];
	assign r2  = ge2 ? d2[23:0] : {r1[22:0], dvd_q[56]};

	// Control and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q        <= 1'b0;
			rate_q      <= '0;
			burst_q     <= '0;
			wait_q      <= '0;
			primed_q    <= 1'b0;
			seeded_q    <= 1'b0;
			level_q     <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Register writes; any write to a listed register re-primes the bucket
			if (cfg_valid) begin
				case (cfg_index)
					tbrl_pkg::CFG_ENABLE: en_q    <= cfg_data[0];
					tbrl_pkg::CFG_RATE:   rate_q  <= cfg_data[23:0];
					tbrl_pkg::CFG_BURST:  burst_q <= cfg_data[15:0];
					tbrl_pkg::CFG_WAIT:   wait_q  <= cfg_data;
					default: ;
				endcase
				if (cfg_hit) begin
					primed_q <= 1'b0;
				end
			end

			// First request after reset or a write fills the bucket
			if (cmd.load && !primed_q) begin
				primed_q <= 1'b1;
				level_q  <= {23'b0, cap};
			end
			if (cmd.seed) begin
				seeded_q <= 1'b1;
				last_q   <= now_q;
			end
			if (cmd.refill_apply) begin
				level_q <= clamp_lvl;
				last_q  <= now_q;
			end
			if (cmd.refund) begin
				level_q <= clamp_lvl;
			end
			if (cmd.acq_eval && sts.covers) begin
				level_q <= lvl_less;
			end
			if (cmd.judge && !(dvd_q > {26'b0, wait_q})) begin
				level_q <= lvl_less;
			end

			// Result slot
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= in_func;
			now_q     <= in_now;
			cost_q    <= in_cost;
			allow_w_q <= 1'b1;
			delay_w_q <= '0;
		end
		if (cmd.mul_load) begin
			mcand_q  <= delta[56:0];
			mplier_q <= rate_q;
			acc_q    <= (|delta[63:57]) ? tbrl_pkg::ACC_SAT : '0;
		end
		if (cmd.mul_step) begin
			acc_q    <= acc_nxt;
			mplier_q <= {mplier_q[22:0], 1'b0};
		end
		if (cmd.acq_eval) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[55:0], ge1, ge2};
			rem_q <= r2;
		end
		// Quotient over the limit rejects, else the request waits
		if (cmd.judge) begin
			if (dvd_q > {26'b0, wait_q}) begin
				allow_w_q <= 1'b0;
			end else begin
				delay_w_q <= dvd_q[31:0];
			end
		end
		if (cmd.publish) begin
			allowed_q <= allow_w_q;
			delay_q   <= delay_w_q;
			token_q   <= level_q;
		end
	end

	// Status
	assign sts.func          = func_q;
	assign sts.acq_active    = active;
	assign sts.refund_active = active;
	assign sts.rate_nz       = rate_nz;
	assign sts.seeded        = seeded_q;
	assign sts.time_ahead    = (now_q > last_q);
	assign sts.covers        = (lvl_ext >= cost_ext);
	assign sts.out_free      = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign allowed        = allowed_q;
	assign retry_after_ms = delay_q;
	assign token_level    = token_q;

endmodule

`default_nettype wire

/* rtl/tbrl_ctrl.sv */
`default_nettype none

module tbrl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tbrl_pkg::sts_t  sts,
	output tbrl_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_MUL,
		S_CLAMP,
		S_ACQ,
		S_DIV,
		S_JUDGE,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [tbrl_pkg::STEP_W-1:0]   step_q;
	logic                          in_ready_q;
	logic                          accept;
	logic                          need_refill;
	logic                          is_acq;

	assign accept      = in_valid && in_ready_q;
	assign is_acq      = (sts.func == tbrl_pkg::FUNC_ACQUIRE);
	assign need_refill = (is_acq && sts.acq_active) ||
	                     ((sts.func == tbrl_pkg::FUNC_PEEK) && sts.rate_nz);

	// Command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE:   cmd.load = accept;
			S_DECIDE: begin
				cmd.seed     = need_refill && !sts.seeded;
				cmd.mul_load = need_refill && sts.seeded && sts.time_ahead;
				cmd.refund   = (sts.func == tbrl_pkg::FUNC_REFUND) && sts.refund_active;
			end
			S_MUL:    cmd.mul_step     = 1'b1;
			S_CLAMP:  cmd.refill_apply = 1'b1;
			S_ACQ:    cmd.acq_eval     = 1'b1;
			S_DIV:    cmd.div_step     = 1'b1;
			S_JUDGE:  cmd.judge        = 1'b1;
			S_DONE:   cmd.publish      = sts.out_free;
			default:  cmd = '0;
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_ready_q <= 1'b0;
						state_q    <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					step_q <= '0;
					if (need_refill && sts.seeded && sts.time_ahead) begin
						state_q <= S_MUL;
					end else if (need_refill && is_acq) begin
						state_q <= S_ACQ;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					if (step_q == tbrl_pkg::STEP_W'(tbrl_pkg::MUL_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= S_CLAMP;
					end else begin
						step_q <= step_q + tbrl_pkg::STEP_W'(1);
					end
				end
				S_CLAMP: begin
					state_q <= is_acq ? S_ACQ : S_DONE;
				end
				S_ACQ: begin
					step_q  <= '0;
					state_q <= sts.covers ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (step_q == tbrl_pkg::STEP_W'(tbrl_pkg::DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= S_JUDGE;
					end else begin
						step_q <= step_q + tbrl_pkg::STEP_W'(1);
					end
				end
				S_JUDGE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) begin
						in_ready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign in_ready = in_ready_q;

endmodule

`default_nettype wire
